@@ rtl/mfmt_pkg.sv @@
// Package: constants and types shared by the multi-turn tracker files.
package mfmt_pkg;

  localparam int unsigned COUNTS_PER_TURN = 8192;
  localparam int unsigned HALF_TURN = COUNTS_PER_TURN / 2;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TURN_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register word index (paddr[2])
  localparam logic REG_DIRECTION = 1'b0;

  typedef enum logic {
    DIR_FORWARD = 1'b0,
    DIR_REVERSE = 1'b1
  } dir_e;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
  } frame_t;

endpackage

@@ rtl/mfmt_if.sv @@
// Interfaces: feedback frame channel and tracker result channel.
interface mfmt_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic [7:0] byte_4;
  logic [7:0] byte_5;
  logic [7:0] byte_6;

  modport source (
    output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6,
    input  ready
  );
  modport sink (
    input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6,
    output ready
  );
endinterface

interface mfmt_result_if;
  logic               valid;
  logic               ready;
  logic        [15:0] rotor_angle;
  logic signed [15:0] shaft_speed;
  logic signed [15:0] torque_current;
  logic signed [7:0]  temperature;
  logic signed [31:0] turn_count;
  logic signed [31:0] total_position;

  modport source (
    output valid, rotor_angle, shaft_speed, torque_current, temperature,
           turn_count, total_position,
    input  ready
  );
  modport sink (
    input  valid, rotor_angle, shaft_speed, torque_current, temperature,
           turn_count, total_position,
    output ready
  );
endinterface

@@ rtl/motor_feedback_multiturn_tracker.sv @@
// Top level: feedback frame decode and multi-turn angle unwrap with APB register.
// A request passes through the single input register and then the result register.
// Throughput: one request per cycle while result_o.ready does not stall the output.
// The turn counter and its scaled position advance incrementally, so no multiplier.
// Reset: rst_ni clears both valid flags, the active flag, angles, turns and direction.
// The first request after reset latches the initial angle; turns start at zero.
module motor_feedback_multiturn_tracker
  import mfmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  mfmt_frame_if.sink            frame_i,
  mfmt_result_if.source         result_o
);

  localparam logic signed [ANGLE_W:0] HalfTurnS = (ANGLE_W + 1)'(HALF_TURN);
  localparam logic [TURN_W-1:0] TurnStep = TURN_W'(COUNTS_PER_TURN);

  dir_e                dir_q;
  logic                s1_valid_q;
  frame_t              s1_q;
  logic                res_valid_q;
  logic                active_q;
  logic [ANGLE_W-1:0]  init_angle_q;
  logic [ANGLE_W-1:0]  last_angle_q;
  logic [TURN_W-1:0]   turns_q;
  logic [TURN_W-1:0]   base_q;

  logic                cfg_wr;
  logic                s1_adv;
  logic [ANGLE_W-1:0]  angle;
  logic [ANGLE_W-1:0]  init_angle;
  logic [ANGLE_W-1:0]  last_angle;
  logic signed [ANGLE_W:0] diff;
  logic signed [ANGLE_W:0] off_s;
  logic                turn_inc;
  logic                turn_dec;
  logic [TURN_W-1:0]   turns_d;
  logic [TURN_W-1:0]   base_d;
  logic [TURN_W-1:0]   off_ext;
  logic [TURN_W-1:0]   offset;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign prdata = (paddr[2] == REG_DIRECTION) ? APB_DATA_W'(dir_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_FORWARD;
    end else if (cfg_wr) begin
      dir_q <= dir_e'(pwdata[0]);
    end
  end

  // handshake
  assign s1_adv = s1_valid_q && (!res_valid_q || result_o.ready);
  assign frame_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (frame_i.ready) begin
        s1_valid_q <= frame_i.valid;
      end
      if (s1_adv) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      s1_q <= '{byte_0: frame_i.byte_0, byte_1: frame_i.byte_1,
                byte_2: frame_i.byte_2, byte_3: frame_i.byte_3,
                byte_4: frame_i.byte_4, byte_5: frame_i.byte_5,
                byte_6: frame_i.byte_6};
    end
  end

  // unwrap
  assign angle      = {s1_q.byte_0, s1_q.byte_1};
  assign init_angle = active_q ? init_angle_q : angle;
  assign last_angle = active_q ? last_angle_q : angle;
  assign diff  = signed'({1'b0, angle}) - signed'({1'b0, last_angle});
  assign off_s = signed'({1'b0, angle}) - signed'({1'b0, init_angle});

  assign turn_inc = ((diff < -HalfTurnS) && (dir_q == DIR_FORWARD)) ||
                    ((diff > HalfTurnS) && (dir_q == DIR_REVERSE));
  assign turn_dec = ((diff > HalfTurnS) && (dir_q == DIR_FORWARD)) ||
                    ((diff < -HalfTurnS) && (dir_q == DIR_REVERSE));

  always_comb begin
    priority if (turn_inc) begin
      turns_d = turns_q + TURN_W'(1);
      base_d  = base_q + TurnStep;
    end else if (turn_dec) begin
      turns_d = turns_q - TURN_W'(1);
      base_d  = base_q - TurnStep;
    end else begin
      turns_d = turns_q;
      base_d  = base_q;
    end
  end

  assign off_ext = {{(TURN_W - ANGLE_W - 1){off_s[ANGLE_W]}}, off_s};
  assign offset  = (dir_q == DIR_REVERSE) ? (TURN_W'(0) - off_ext) : off_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      init_angle_q <= '0;
      last_angle_q <= '0;
      turns_q      <= '0;
      base_q       <= '0;
    end else if (s1_adv) begin
      active_q     <= 1'b1;
      init_angle_q <= init_angle;
      last_angle_q <= angle;
      turns_q      <= turns_d;
      base_q       <= base_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_o.rotor_angle    <= angle;
      result_o.shaft_speed    <= signed'({s1_q.byte_2, s1_q.byte_3});
      result_o.torque_current <= signed'({s1_q.byte_4, s1_q.byte_5});
      result_o.temperature    <= signed'(s1_q.byte_6);
      result_o.turn_count     <= signed'(turns_d);
      result_o.total_position <= signed'(base_d + offset);
    end
  end

  assign result_o.valid = res_valid_q;

  a_active_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> active_q)
    else $error("active flag not set after first request");

  a_base_tracks_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q == TURN_W'(turns_q * TurnStep))
    else $error("scaled position base out of step with turn counter");

  a_turn_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (turns_q == $past(turns_q)) || (turns_q == $past(turns_q) + TURN_W'(1)) ||
    (turns_q == $past(turns_q) - TURN_W'(1)))
    else $error("turn counter moved by more than one");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(turns_q) && $stable(last_angle_q))
    else $error("tracker state changed without a request");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a staged request");

endmodule
